@@ rtl/core/edt_pkg.sv @@
// ----------------------------------------------------------------------------
// edt_pkg: shared definitions for the EDID descriptor text extractor
// Constants, configuration register indexes and the result record type.
// ----------------------------------------------------------------------------
package edt_pkg;

  localparam int POS_W       = 7;
  localparam int POS_MAX     = 127;
  localparam int DESC_SIZE   = 18;
  localparam int DESC_START  = 54;
  localparam int HDR_LEN     = 5;
  localparam int TAG_HDR_OFF = 3;

  localparam int DESCRIPTOR_COUNT_DEFAULT = 4;
  localparam int TEXT_LENGTH_DEFAULT      = 13;

  localparam int VENDOR_HI_POS = 8;
  localparam int VENDOR_LO_POS = 9;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [7:0]  TAG_RESET  = 8'hFC;
  localparam logic [15:0] MFR_RESET  = 16'h10AC;
  localparam logic [7:0]  CHAR_DOT   = 8'h2E;
  localparam logic [7:0]  CHAR_NUL   = 8'h00;
  localparam logic [7:0]  CHAR_LF    = 8'h0A;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DESCRIPTOR_TAG  = 1'b0,
    CFG_MANUFACTURER_ID = 1'b1
  } cfg_index_t;

  typedef enum logic {
    KIND_TEXT    = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_t;

  typedef struct packed {
    result_kind_t kind;
    logic [7:0]   text_char;
    logic         descriptor_found;
    logic         vendor_match;
    logic         last_result;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

  function automatic logic is_alnum(input logic [7:0] c);
    is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

@@ rtl/core/edt_parser.sv @@
// ----------------------------------------------------------------------------
// edt_parser: per-byte EDID parsing
// Tracks byte position and descriptor offset, matches descriptor headers and
// the vendor ID, and forms up to two results for each accepted byte.
// ----------------------------------------------------------------------------
module edt_parser
  import edt_pkg::*;
#(
  parameter int DESCRIPTOR_COUNT = DESCRIPTOR_COUNT_DEFAULT,
  parameter int TEXT_LENGTH      = TEXT_LENGTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  logic [7:0]   edid_byte,
  input  logic         end_of_edid,
  input  logic [7:0]   descriptor_tag,
  input  logic [15:0]  manufacturer_id,
  output result_pair_t results
);

  localparam int OFF_W    = $clog2(DESC_SIZE);
  localparam int AREA_END = DESC_START + DESC_SIZE * DESCRIPTOR_COUNT;
  localparam int TEXT_END = HDR_LEN - 1 + TEXT_LENGTH;

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [OFF_W-1:0] desc_off, desc_off_next;
  logic header_matching, header_matching_next;
  logic found_flag, found_flag_next;
  logic text_stopped, text_stopped_next;
  logic vendor_first_ok, vendor_first_ok_next;
  logic vendor_ok, vendor_ok_next;

  logic       in_area;
  logic       emit;
  logic       hdr_ok;
  logic [7:0] ch;
  result_t    char_res;
  result_t    sum_res;

  always_comb begin
    in_area = (byte_position >= POS_W'(DESC_START)) &&
              ({1'b0, byte_position} < (POS_W + 1)'(AREA_END));
    byte_position_next   = byte_position;
    desc_off_next        = desc_off;
    header_matching_next = header_matching;
    found_flag_next      = found_flag;
    text_stopped_next    = text_stopped;
    vendor_first_ok_next = vendor_first_ok;
    vendor_ok_next       = vendor_ok;
    emit   = 1'b0;
    hdr_ok = 1'b0;
    ch     = is_alnum(edid_byte) ? edid_byte : CHAR_DOT;

    if (byte_position == POS_W'(VENDOR_HI_POS)) begin
      vendor_first_ok_next = (edid_byte == manufacturer_id[15:8]);
    end else if (byte_position == POS_W'(VENDOR_LO_POS)) begin
      vendor_ok_next = vendor_first_ok && (edid_byte == manufacturer_id[7:0]);
    end

    if (in_area) begin
      desc_off_next = (desc_off == OFF_W'(DESC_SIZE - 1)) ? '0 : desc_off + 1'b1;
      if (!found_flag) begin
        if (desc_off < OFF_W'(HDR_LEN)) begin
          hdr_ok = (desc_off == OFF_W'(TAG_HDR_OFF)) ? (edid_byte == descriptor_tag)
                                                    : (edid_byte == 8'h00);
          header_matching_next = (desc_off == '0) ? hdr_ok : (header_matching && hdr_ok);
          if (desc_off == OFF_W'(HDR_LEN - 1) && header_matching_next) begin
            found_flag_next = 1'b1;
          end
        end
      end else if (!text_stopped && desc_off >= OFF_W'(HDR_LEN)) begin
        if (edid_byte == CHAR_NUL || edid_byte == CHAR_LF) begin
          text_stopped_next = 1'b1;
        end else begin
          emit = 1'b1;
          if ({1'b0, desc_off} >= (OFF_W + 1)'(TEXT_END)) begin
            text_stopped_next = 1'b1;
          end
        end
      end
    end

    if (byte_position != POS_W'(POS_MAX)) begin
      byte_position_next = byte_position + 1'b1;
    end

    char_res.kind             = KIND_TEXT;
    char_res.text_char        = ch;
    char_res.descriptor_found = 1'b0;
    char_res.vendor_match     = 1'b0;
    char_res.last_result      = !end_of_edid;

    sum_res.kind             = KIND_SUMMARY;
    sum_res.text_char        = 8'h00;
    sum_res.descriptor_found = found_flag_next;
    sum_res.vendor_match     = vendor_ok_next;
    sum_res.last_result      = 1'b1;

    results.count  = {1'b0, emit} + {1'b0, end_of_edid};
    results.first  = emit ? char_res : sum_res;
    results.second = sum_res;

    if (end_of_edid) begin
      byte_position_next   = '0;
      desc_off_next        = '0;
      header_matching_next = 1'b1;
      found_flag_next      = 1'b0;
      text_stopped_next    = 1'b0;
      vendor_first_ok_next = 1'b0;
      vendor_ok_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      desc_off        <= '0;
      header_matching <= 1'b1;
      found_flag      <= 1'b0;
      text_stopped    <= 1'b0;
      vendor_first_ok <= 1'b0;
      vendor_ok       <= 1'b0;
    end else if (fire) begin
      byte_position   <= byte_position_next;
      desc_off        <= desc_off_next;
      header_matching <= header_matching_next;
      found_flag      <= found_flag_next;
      text_stopped    <= text_stopped_next;
      vendor_first_ok <= vendor_first_ok_next;
      vendor_ok       <= vendor_ok_next;
    end
  end

endmodule

@@ rtl/core/edid_descriptor_text_extractor.sv @@
// ----------------------------------------------------------------------------
// edid_descriptor_text_extractor: EDID display descriptor text extractor
// Streams EDID bytes in and emits the text of the first matching display
// descriptor, followed by a found / vendor-match summary at the last byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one EDID byte per transaction, with
//   end_of_edid set on the final byte. Output channel (out_valid/out_ready):
//   one result per transaction, text characters then a summary record.
//   cfg_we/cfg_index/cfg_data write descriptor_tag (index 0) and
//   manufacturer_id (index 1); write only while the block is idle.
//   A result is registered into the buffer when its byte is accepted.
//   Throughput: one byte per cycle while in_ready holds. The results of a
//   byte are queued in a four-entry result buffer; a byte is taken while at
//   least two entries are free, so a byte that yields two results (final
//   text character plus the summary) takes two transactions on the single
//   output port. A stalled receiver fills the buffer and then deasserts
//   in_ready; nothing is dropped.
//   Reset: synchronous; clears parser state and the buffer and loads the
//   register defaults (tag 0xFC, manufacturer ID 0x10AC).
// ----------------------------------------------------------------------------
module edid_descriptor_text_extractor
  import edt_pkg::*;
#(
  parameter int DESCRIPTOR_COUNT = DESCRIPTOR_COUNT_DEFAULT,
  parameter int TEXT_LENGTH      = TEXT_LENGTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             edid_byte,
  input  logic                   end_of_edid,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   result_kind,
  output logic [7:0]             text_char,
  output logic                   descriptor_found,
  output logic                   vendor_match,
  output logic                   last_result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [7:0]  descriptor_tag;
  logic [15:0] manufacturer_id;

  result_pair_t results;
  result_t      buffer [DEPTH];
  result_t      head;
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic in_fire, out_fire;

  assign in_ready  = (count <= CNT_W'(DEPTH - 2));
  assign out_valid = (count != '0);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      descriptor_tag  <= TAG_RESET;
      manufacturer_id <= MFR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DESCRIPTOR_TAG:  descriptor_tag  <= cfg_data[7:0];
        CFG_MANUFACTURER_ID: manufacturer_id <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  edt_parser #(
    .DESCRIPTOR_COUNT(DESCRIPTOR_COUNT),
    .TEXT_LENGTH     (TEXT_LENGTH)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .fire           (in_fire),
    .edid_byte      (edid_byte),
    .end_of_edid    (end_of_edid),
    .descriptor_tag (descriptor_tag),
    .manufacturer_id(manufacturer_id),
    .results        (results)
  );

  always_comb begin
    count_next = count;
    if (in_fire) begin
      count_next = count_next + CNT_W'(results.count);
    end
    if (out_fire) begin
      count_next = count_next - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (results.count != 2'd0) begin
        buffer[wr_ptr] <= results.first;
      end
      if (results.count == 2'd2) begin
        buffer[wr_ptr + 1'b1] <= results.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (in_fire) begin
        wr_ptr <= wr_ptr + PTR_W'(results.count);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  assign head             = buffer[rd_ptr];
  assign result_kind      = head.kind;
  assign text_char        = head.text_char;
  assign descriptor_found = head.descriptor_found;
  assign vendor_match     = head.vendor_match;
  assign last_result      = head.last_result;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("result buffer count exceeds depth");

  a_room_on_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> (count <= CNT_W'(DEPTH - 2)))
    else $error("byte accepted without room for two results");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (count == '0) && !out_valid)
    else $error("result buffer not empty after reset");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_SUMMARY) |-> last_result)
    else $error("summary record not flagged as last result");

endmodule

@@ test/edid_descriptor_text_extractor_test.sv @@
// ----------------------------------------------------------------------------
// edid_descriptor_text_extractor_test: self-checking bench for the extractor
// Streams directed and randomly built EDID images through the block. Random
// gaps and stalls are applied on both channels, and the tag and manufacturer
// ID registers are changed between phases. A byte-level predictor in the
// bench computes the expected text characters and summaries for each accepted
// byte. Every output transaction is checked against the oldest expected one.
// ----------------------------------------------------------------------------
module edid_descriptor_text_extractor_test;
  import edt_pkg::*;

  localparam int DESCRIPTOR_COUNT = DESCRIPTOR_COUNT_DEFAULT;
  localparam int TEXT_LENGTH      = TEXT_LENGTH_DEFAULT;
  localparam int DESC_END         = DESC_START + DESC_SIZE * DESCRIPTOR_COUNT;
  localparam int IMG_SIZE         = 200;
  localparam int HOLD_CYCLES      = 150;
  localparam logic [7:0] BORDER_CHARS [12] = '{8'h2F, 8'h30, 8'h39, 8'h3A, 8'h40,
    8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
  } edid_item_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             edid_byte = 8'h00;
  logic                   end_of_edid = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   result_kind;
  logic [7:0]             text_char;
  logic                   descriptor_found;
  logic                   vendor_match;
  logic                   last_result;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  edid_descriptor_text_extractor uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .edid_byte(edid_byte), .end_of_edid(end_of_edid),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .text_char(text_char),
    .descriptor_found(descriptor_found), .vendor_match(vendor_match),
    .last_result(last_result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state and register copies
  logic [7:0]       tag_reg = TAG_RESET;
  logic [15:0]      mfr_reg = MFR_RESET;
  logic [POS_W-1:0] pos = '0;
  logic             hdr_ok = 1'b1;
  logic             found = 1'b0;
  logic             stopped = 1'b0;
  logic             vend_hi_ok = 1'b0;
  logic             vend_ok = 1'b0;

  edid_item_t pending_bytes [$];
  result_t    expected_results [$];
  logic [7:0] edid_img [IMG_SIZE];
  edid_item_t cur_item = '0;
  bit         offering = 1'b0;
  bit         byte_taken = 1'b0;
  bit         result_taken = 1'b0;
  bit         hold_req = 1'b0;
  int         send_wait = 0;
  int         recv_wait = 0;
  int         send_mode = 1;
  int         recv_mode = 1;
  int         queued = 0;
  int         errors = 0;

  function automatic int draw_gap(input int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 18);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
  endfunction

  task automatic extract_byte(input logic [7:0] b, input logic fin);
    result_t r [2];
    int      n;
    int      p;
    int      off;
    logic    ok;
    n = 0;
    p = pos;
    if (p == VENDOR_HI_POS) vend_hi_ok = (b == mfr_reg[15:8]);
    else if (p == VENDOR_LO_POS) vend_ok = vend_hi_ok && (b == mfr_reg[7:0]);
    if (p >= DESC_START && p < DESC_END) begin
      off = (p - DESC_START) % DESC_SIZE;
      if (!found) begin
        if (off < HDR_LEN) begin
          ok = (b == ((off == TAG_HDR_OFF) ? tag_reg : 8'h00));
          hdr_ok = (off == 0) ? ok : (hdr_ok && ok);
          if (off == HDR_LEN - 1 && hdr_ok) found = 1'b1;
        end
      end else if (!stopped && off >= HDR_LEN) begin
        if (b == CHAR_NUL || b == CHAR_LF) begin
          stopped = 1'b1;
        end else begin
          r[n] = '0;
          r[n].kind = KIND_TEXT;
          r[n].text_char = (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ?
                           b : CHAR_DOT;
          n++;
          if (off >= HDR_LEN - 1 + TEXT_LENGTH) stopped = 1'b1;
        end
      end
    end
    if (pos != POS_MAX) pos++;
    if (fin) begin
      r[n] = '0;
      r[n].kind = KIND_SUMMARY;
      r[n].descriptor_found = found;
      r[n].vendor_match = vend_ok;
      n++;
      pos = '0;
      hdr_ok = 1'b1;
      found = 1'b0;
      stopped = 1'b0;
      vend_hi_ok = 1'b0;
      vend_ok = 1'b0;
    end
    if (n > 0) r[n-1].last_result = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(r[i]);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none, actual kind=%0d char=%h",
               $time, result_kind, text_char);
    end else begin
      want = expected_results.pop_front();
      check_field("result_kind", want.kind, result_kind);
      check_field("text_char", want.text_char, text_char);
      check_field("descriptor_found", want.descriptor_found, descriptor_found);
      check_field("vendor_match", want.vendor_match, vendor_match);
      check_field("last_result", want.last_result, last_result);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        extract_byte(edid_byte, end_of_edid);
        byte_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        check_result();
        result_taken = 1'b1;
      end
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (byte_taken) begin
        byte_taken = 1'b0;
        offering = 1'b0;
        send_wait = draw_gap(send_mode);
      end
      if (!offering) begin
        if (send_wait != 0) begin
          send_wait--;
        end else if (pending_bytes.size() != 0) begin
          cur_item = pending_bytes.pop_front();
          offering = 1'b1;
        end
      end
      in_valid <= offering;
      edid_byte <= cur_item.b;
      end_of_edid <= cur_item.fin;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (result_taken) begin
        result_taken = 1'b0;
        recv_wait = draw_gap(recv_mode);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        recv_wait = HOLD_CYCLES;
      end
      if (recv_wait != 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(0, 61);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        if (r < 10) return 8'(8'h30 + r);
        if (r < 36) return 8'(8'h41 + r - 10);
        return 8'(8'h61 + r - 36);
      end
      4: return BORDER_CHARS[$urandom_range(0, 11)];
      5: return 8'($urandom_range(8'h20, 8'h2F));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic build_edid(input bit force_hit, output int len);
    int sel;
    int base;
    int stop_at;
    sel = $urandom_range(0, 9);
    if (force_hit || sel < 5) len = 128;
    else if (sel < 7) len = DESC_START + $urandom_range(1, DESC_END - DESC_START);
    else if (sel < 9) len = $urandom_range(1, DESC_START);
    else len = $urandom_range(129, IMG_SIZE - 1);
    for (int k = 0; k < IMG_SIZE; k++) edid_img[k] = 8'($urandom);
    sel = $urandom_range(0, 3);
    if (sel != 0) begin
      edid_img[VENDOR_HI_POS] = mfr_reg[15:8];
      if (sel != 1) edid_img[VENDOR_LO_POS] = mfr_reg[7:0];
    end
    for (int d = 0; d < DESCRIPTOR_COUNT; d++) begin
      base = DESC_START + d * DESC_SIZE;
      sel = (force_hit && d == 0) ? 0 : $urandom_range(0, 5);
      if (sel < 4) begin
        for (int k = 0; k < HDR_LEN; k++)
          edid_img[base + k] = (k == TAG_HDR_OFF) ? tag_reg : 8'h00;
        if (sel == 3)
          edid_img[base + $urandom_range(0, HDR_LEN - 1)] ^= 8'(1 << $urandom_range(0, 7));
      end
      stop_at = force_hit ? DESC_SIZE : $urandom_range(HDR_LEN, 24);
      for (int k = HDR_LEN; k < DESC_SIZE; k++) begin
        if (k == stop_at) edid_img[base + k] = $urandom_range(0, 1) ? CHAR_LF : CHAR_NUL;
        else edid_img[base + k] = text_byte();
      end
    end
  endtask

  task automatic push_span(input int lo, input int hi, input bit closes);
    edid_item_t it;
    for (int k = lo; k <= hi; k++) begin
      it.b = edid_img[k];
      it.fin = closes && (k == hi);
      pending_bytes.push_back(it);
      queued++;
    end
  endtask

  task automatic queue_random(input int target);
    edid_item_t it;
    int         len;
    int         cnt;
    while (queued < target) begin
      if ($urandom_range(0, 9) == 0) begin
        cnt = $urandom_range(1, 12);
        for (int k = 0; k < cnt; k++) begin
          it.b = 8'($urandom);
          it.fin = (k == cnt - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 5) == 0);
          pending_bytes.push_back(it);
          queued++;
        end
      end else begin
        build_edid(1'b0, len);
        push_span(0, len - 1, 1'b1);
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || offering || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_DESCRIPTOR_TAG:  tag_reg = val[7:0];
      CFG_MANUFACTURER_ID: mfr_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int len;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // lone final bytes, then short images cut at the vendor bytes
    for (int k = 0; k < IMG_SIZE; k++) edid_img[k] = 8'($urandom);
    edid_img[0] = 8'h00;
    edid_img[1] = 8'hFF;
    push_span(0, 0, 1'b1);
    push_span(1, 1, 1'b1);
    edid_img[VENDOR_HI_POS] = mfr_reg[15:8];
    edid_img[VENDOR_LO_POS] = mfr_reg[7:0];
    push_span(0, VENDOR_HI_POS, 1'b1);
    push_span(0, VENDOR_LO_POS, 1'b1);
    queue_random(200);
    wait_idle();

    write_reg(CFG_DESCRIPTOR_TAG, 16'h00FF);
    write_reg(CFG_MANUFACTURER_ID, 16'hFFFF);
    send_mode = 0;
    recv_mode = 0;
    queue_random(400);
    wait_idle();

    write_reg(CFG_DESCRIPTOR_TAG, 16'h0000);
    write_reg(CFG_MANUFACTURER_ID, 16'h0000);
    send_mode = 2;
    recv_mode = 1;
    queue_random(600);
    wait_idle();

    // receiver stalls long enough for the block to back up its input
    write_reg(CFG_DESCRIPTOR_TAG, 16'h00FE);
    write_reg(CFG_MANUFACTURER_ID, 16'($urandom));
    send_mode = 0;
    build_edid(1'b1, len);
    push_span(0, len - 1, 1'b1);
    hold_req = 1'b1;
    recv_mode = 2;
    queue_random(800);
    wait_idle();

    // tag changes while an image is half way through its first header
    write_reg(CFG_MANUFACTURER_ID, 16'($urandom));
    build_edid(1'b1, len);
    push_span(0, DESC_START + 2, 1'b0);
    wait_idle();
    write_reg(CFG_DESCRIPTOR_TAG, 16'($urandom_range(0, 255)));
    edid_img[DESC_START + TAG_HDR_OFF] = tag_reg;
    push_span(DESC_START + 3, len - 1, 1'b1);
    send_mode = 2;
    recv_mode = 0;
    queue_random(950);
    wait_idle();

    write_reg(CFG_DESCRIPTOR_TAG, {8'h00, TAG_RESET});
    write_reg(CFG_MANUFACTURER_ID, MFR_RESET);
    send_mode = 1;
    recv_mode = 1;
    queue_random(1000);
    wait_idle();

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
